FILE: src/vpa_pkg.sv
// shared types and constants of the variable partition allocator
// segment entry layout, request and status codes, sequencer states
// no dependencies
package vpa_pkg;

  localparam int MaxSeg = 64;
  localparam int IdxW   = $clog2(MaxSeg);
  localparam int CntW   = $clog2(MaxSeg + 1);
  localparam int UnitW  = 16;
  localparam int EntW   = 1 + 2 * UnitW;

  typedef struct packed {
    logic             free;
    logic [UnitW-1:0] owner;
    logic [UnitW-1:0] size;
  } entry_t;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_COMPACT = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_NO_OWNER = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_SPARE = 2'd3
  } fit_t;

  localparam logic [2:0] RegTotal  = 3'd0;
  localparam logic [2:0] RegPolicy = 3'd4;

  typedef enum logic [9:0] {
    S_INIT    = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_SCAN    = 10'b00_0000_0100,
    S_SHIFT   = 10'b00_0000_1000,
    S_SPLIT   = 10'b00_0001_0000,
    S_FINW    = 10'b00_0010_0000,
    S_MERGE   = 10'b00_0100_0000,
    S_COMPACT = 10'b00_1000_0000,
    S_STATS   = 10'b01_0000_0000,
    S_OUT     = 10'b10_0000_0000
  } state_t;

endpackage

FILE: src/vpa_ram.sv
// generic single-clock ram, one write port and one read port
// read data registered; no dependencies
module vpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/variable_partition_allocator_unit.sv
// variable partition allocator: segment table in ram, walked by a sequencer
// depends on vpa_pkg and vpa_ram
//
// usage: requests enter on the in_ stream (tuser = request kind, tdata =
// owner id and size); each item gives one result on the out_ stream
// (status, units in use, largest free segment). total_memory and fit_policy
// are set through the apb port; writing total_memory reloads the table with
// one free segment.
// an alloc or free item takes one table walk to search and, where needed, a
// second walk for merge or the entry shift of a split; a compact item takes
// one compact walk instead. every item ends with one more walk that gathers
// the used total and largest free segment. the segment ram has a single read
// port, so each walk reads the entries one after another.
// one item is worked on at a time; in_tready is high only between items.
// the result sits in an output register, so the next item is taken while a
// result still waits; if the receiver stalls longer, the finished item waits
// in the sequencer until the output register frees up.
// after reset the table holds one free segment of 500 units, first fit.
module variable_partition_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // owner id, size
  input  logic [1:0]  in_tuser,    // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // status, used_total, largest_free, zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import vpa_pkg::*;

  state_t           state_r, state_nxt;
  logic [UnitW-1:0] total_r;
  logic [1:0]       policy_r;
  logic [1:0]       req_r, req_nxt;
  logic [UnitW-1:0] pid_r, pid_nxt, want_r, want_nxt;
  logic [CntW-1:0]  count_r, count_nxt, scan_r, scan_nxt, n_r, n_nxt;
  logic             p_vld_r, p_vld_nxt;
  logic [IdxW-1:0]  p_idx_r, p_idx_nxt, pick_r, pick_nxt;
  logic             found_r, found_nxt, hv_r, hv_nxt;
  logic [UnitW-1:0] psize_r, psize_nxt, large_r, large_nxt;
  entry_t           acc_r, acc_nxt;
  logic [UnitW:0]   used_r, used_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             out_vld_r;
  logic [1:0]       o_status_r;
  logic [UnitW-1:0] o_used_r, o_large_r;

  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  entry_t           ram_wd, e, em;
  logic [EntW-1:0]  ram_rdata;
  logic             scan_go, sh_go, walk_end, cfg_wr;
  logic [UnitW-1:0] rest;

  vpa_ram #(.WIDTH(EntW), .DEPTH(MaxSeg)) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wd),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = cfg_paddr[2] ? {30'd0, policy_r} : {16'd0, total_r};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, o_large_r, o_used_r, o_status_r};

  assign e        = entry_t'(ram_rdata);
  assign scan_go  = scan_r < count_r;
  assign sh_go    = scan_r > {1'b0, pick_r};
  assign walk_end = !scan_go && !p_vld_r;
  assign rest     = psize_r - want_r;

  // entry as seen by the merge walk: the released segment reads as free
  always_comb begin
    em = e;
    if (p_idx_r == pick_r) begin
      em.free = 1'b1;
    end
    if (em.free) begin
      em.owner = '0;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    pid_nxt    = pid_r;
    want_nxt   = want_r;
    count_nxt  = count_r;
    scan_nxt   = scan_r;
    n_nxt      = n_r;
    p_vld_nxt  = 1'b0;
    p_idx_nxt  = p_idx_r;
    pick_nxt   = pick_r;
    found_nxt  = found_r;
    hv_nxt     = hv_r;
    psize_nxt  = psize_r;
    large_nxt  = large_r;
    acc_nxt    = acc_r;
    used_nxt   = used_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wd     = '0;
    ram_re     = 1'b0;
    ram_raddr  = scan_r[IdxW-1:0];

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wd    = '{free: 1'b1, owner: '0, size: total_r};
        count_nxt = CntW'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt    = in_tuser;
          pid_nxt    = in_tdata[15:0];
          want_nxt   = in_tdata[31:16];
          scan_nxt   = '0;
          n_nxt      = '0;
          found_nxt  = 1'b0;
          hv_nxt     = 1'b0;
          used_nxt   = '0;
          large_nxt  = '0;
          status_nxt = ST_DONE;
          case (in_tuser)
            REQ_ALLOC, REQ_FREE: state_nxt = S_SCAN;
            REQ_COMPACT:         state_nxt = S_COMPACT;
            default:             state_nxt = S_STATS;
          endcase
        end
      end
      S_SCAN: begin
        ram_re = scan_go;
        if (scan_go) begin
          scan_nxt = scan_r + 1'b1;
        end
        p_vld_nxt = scan_go;
        p_idx_nxt = scan_r[IdxW-1:0];
        if (p_vld_r) begin
          if (req_r == REQ_ALLOC) begin
            if (e.free && e.size >= want_r) begin
              if (!found_r ||
                  (policy_r == FIT_BEST && e.size < psize_r) ||
                  (policy_r == FIT_WORST && e.size > psize_r)) begin
                found_nxt = 1'b1;
                pick_nxt  = p_idx_r;
                psize_nxt = e.size;
              end
            end
          end else if (!found_r && !e.free && e.owner == pid_r) begin
            found_nxt = 1'b1;
            pick_nxt  = p_idx_r;
          end
        end
        if (walk_end) begin
          scan_nxt = '0;
          if (req_r == REQ_ALLOC) begin
            if (want_r == '0 || !found_r) begin
              status_nxt = ST_NO_FIT;
              state_nxt  = S_STATS;
            end else if (rest != '0) begin
              if (count_r >= CntW'(MaxSeg)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_STATS;
              end else begin
                scan_nxt  = count_r - 1'b1;
                state_nxt = S_SHIFT;
              end
            end else begin
              state_nxt = S_FINW;
            end
          end else if (!found_r) begin
            status_nxt = ST_NO_OWNER;
            state_nxt  = S_STATS;
          end else begin
            state_nxt = S_MERGE;
          end
        end
      end
      S_SHIFT: begin
        // descending copy: read k while k+2 is being written
        ram_re    = sh_go;
        p_vld_nxt = sh_go;
        p_idx_nxt = scan_r[IdxW-1:0];
        if (sh_go) begin
          scan_nxt = scan_r - 1'b1;
        end
        if (p_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = p_idx_r + 1'b1;
          ram_wd    = e;
        end
        if (!sh_go && !p_vld_r) begin
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = pick_r + 1'b1;
        ram_wd    = '{free: 1'b1, owner: '0, size: rest};
        count_nxt = count_r + 1'b1;
        state_nxt = S_FINW;
      end
      S_FINW: begin
        ram_we    = 1'b1;
        ram_waddr = pick_r;
        ram_wd    = '{free: 1'b0, owner: pid_r, size: want_r};
        scan_nxt  = '0;
        state_nxt = S_STATS;
      end
      S_MERGE: begin
        ram_re = scan_go;
        if (scan_go) begin
          scan_nxt = scan_r + 1'b1;
        end
        p_vld_nxt = scan_go;
        p_idx_nxt = scan_r[IdxW-1:0];
        if (p_vld_r) begin
          if (hv_r && em.free && acc_r.free) begin
            acc_nxt.size = acc_r.size + em.size;
          end else begin
            if (hv_r) begin
              ram_we    = 1'b1;
              ram_waddr = n_r[IdxW-1:0];
              ram_wd    = acc_r;
              n_nxt     = n_r + 1'b1;
            end
            acc_nxt = em;
            hv_nxt  = 1'b1;
          end
        end
        if (walk_end) begin
          ram_we    = hv_r;
          ram_waddr = n_r[IdxW-1:0];
          ram_wd    = acc_r;
          count_nxt = n_r + CntW'(hv_r);
          scan_nxt  = '0;
          state_nxt = S_STATS;
        end
      end
      S_COMPACT: begin
        ram_re = scan_go;
        if (scan_go) begin
          scan_nxt = scan_r + 1'b1;
        end
        p_vld_nxt = scan_go;
        p_idx_nxt = scan_r[IdxW-1:0];
        if (p_vld_r && !e.free) begin
          ram_we    = 1'b1;
          ram_waddr = n_r[IdxW-1:0];
          ram_wd    = e;
          n_nxt     = n_r + 1'b1;
          used_nxt  = used_r + {1'b0, e.size};
        end
        if (walk_end) begin
          count_nxt = n_r;
          if (used_r < {1'b0, total_r} && n_r < CntW'(MaxSeg)) begin
            ram_we    = 1'b1;
            ram_waddr = n_r[IdxW-1:0];
            ram_wd    = '{free: 1'b1, owner: '0, size: total_r - used_r[UnitW-1:0]};
            count_nxt = n_r + 1'b1;
          end
          scan_nxt  = '0;
          used_nxt  = '0;
          state_nxt = S_STATS;
        end
      end
      S_STATS: begin
        ram_re = scan_go;
        if (scan_go) begin
          scan_nxt = scan_r + 1'b1;
        end
        p_vld_nxt = scan_go;
        p_idx_nxt = scan_r[IdxW-1:0];
        if (p_vld_r) begin
          if (e.free) begin
            if (e.size > large_r) begin
              large_nxt = e.size;
            end
          end else begin
            used_nxt = used_r + {1'b0, e.size};
          end
        end
        if (walk_end) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_vld_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wr && cfg_paddr[2] == RegTotal[2]) begin
      state_nxt = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      total_r   <= 16'd500;
      policy_r  <= FIT_FIRST;
      count_r   <= CntW'(1);
      scan_r    <= '0;
      p_vld_r   <= 1'b0;
      found_r   <= 1'b0;
      hv_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
      p_vld_r <= p_vld_nxt;
      found_r <= found_nxt;
      hv_r    <= hv_nxt;
      if (cfg_wr) begin
        if (cfg_paddr[2] == RegPolicy[2]) begin
          policy_r <= cfg_pwdata[1:0];
        end else begin
          total_r <= cfg_pwdata[15:0];
        end
      end
      if (state_r == S_OUT && (!out_vld_r || out_tready)) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    pid_r    <= pid_nxt;
    want_r   <= want_nxt;
    n_r      <= n_nxt;
    p_idx_r  <= p_idx_nxt;
    pick_r   <= pick_nxt;
    psize_r  <= psize_nxt;
    large_r  <= large_nxt;
    acc_r    <= acc_nxt;
    used_r   <= used_nxt;
    status_r <= status_nxt;
    if (state_r == S_OUT && (!out_vld_r || out_tready)) begin
      o_status_r <= status_r;
      o_used_r   <= used_r[UnitW-1:0];
      o_large_r  <= large_r;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MaxSeg))
    else $error("segment count beyond table size");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  a_shift_above_pick: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT && ram_we |-> ram_waddr > pick_r)
    else $error("split shift overwrote the chosen segment");

  a_pack_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE || state_r == S_COMPACT) && p_vld_r && ram_we
    |-> n_r[IdxW-1:0] <= p_idx_r)
    else $error("packing write ahead of read pointer");

endmodule
